### sv/ataw_pkg.sv
// Shared types and constants for the ATA status wait engine.
package ataw_pkg;

  // Status register bit positions
  localparam int unsigned StErrBit = 0;
  localparam int unsigned StDrqBit = 3;
  localparam int unsigned StDfBit  = 5;
  localparam int unsigned StBsyBit = 7;

  // Status values that mean no device on the bus
  localparam logic [7:0] StatusFloatLo = 8'h00;
  localparam logic [7:0] StatusFloatHi = 8'hff;

  // Poll budget after reset
  localparam logic [31:0] ResetBudget = 32'd100000;

  // Item functions
  localparam logic FuncBegin  = 1'b0;
  localparam logic FuncSample = 1'b1;

  // Wait goals
  localparam logic [1:0] GoalIdle     = 2'd0;
  localparam logic [1:0] GoalData     = 2'd1;
  localparam logic [1:0] GoalComplete = 2'd2;
  localparam logic [1:0] GoalAlias    = 2'd3;

  typedef enum logic [2:0] {
    CodeOk      = 3'd0,
    CodeNoDev   = 3'd1,
    CodeDevErr  = 3'd2,
    CodeNoDrq   = 3'd3,
    CodeProto   = 3'd4,
    CodeTimeout = 3'd5,
    CodePending = 3'd6
  } code_e;

  typedef struct packed {
    logic       func;
    logic [1:0] goal;
    logic       clear_error;
    logic [7:0] status_byte;
    logic [7:0] error_byte;
  } item_t;

  typedef struct packed {
    logic       waiting;
    logic [1:0] wait_goal;
    logic [7:0] status_rec;
    logic [7:0] error_rec;
    logic       device_ready;
  } ctl_t;

  typedef struct packed {
    logic       done_res;
    code_e      code;
    logic [7:0] saved_status;
    logic [7:0] saved_error;
    logic       device_absent;
  } res_t;

endpackage

### sv/ataw_if.sv
// Valid/ready channel interfaces for the status wait engine.
interface ataw_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] goal;
  logic       clear_error;
  logic [7:0] status_byte;
  logic [7:0] error_byte;

  modport source (output valid, func, goal, clear_error, status_byte, error_byte,
                  input ready);
  modport sink (input valid, func, goal, clear_error, status_byte, error_byte,
                output ready);
endinterface

interface ataw_out_if;
  logic       valid;
  logic       ready;
  logic       done_res;
  logic [2:0] code;
  logic [7:0] saved_status;
  logic [7:0] saved_error;
  logic       device_absent;

  modport source (output valid, done_res, code, saved_status, saved_error, device_absent,
                  input ready);
  modport sink (input valid, done_res, code, saved_status, saved_error, device_absent,
                output ready);
endinterface

### sv/ata_status_wait_engine.sv
// Top level of the bounded ATA status wait engine: registers, handshakes, budget.
// An accepted beat passes through the input register, then the result register.
// Throughput: one beat per cycle unless the result channel stalls; an input
// register and a result register separate the channels, and the wait state
// updates as a beat moves between them.
// Reset (async, active low) clears both valid flags and the wait state, sets
// the device as ready and loads the poll budget with 100000 (masked to BUDGET_BITS).
module ata_status_wait_engine #(
  parameter int unsigned BUDGET_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [23:0]       cfg_wdata_i,
  ataw_in_if.sink           in_if,
  ataw_out_if.source        out_if
);

  logic                   in_valid_q;
  logic                   out_valid_q;
  logic                   in_accept;
  logic                   advance;
  ataw_pkg::item_t        item_q;
  ataw_pkg::ctl_t         ctl_q, ctl_d;
  logic [BUDGET_BITS-1:0] polls_q, polls_d;
  logic [BUDGET_BITS-1:0] budget_q;
  ataw_pkg::res_t         res_q, res_d;

  // Handshakes: input register frees when its beat moves on
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;
  assign in_accept   = in_if.valid && in_if.ready;

  ataw_eval #(
    .BUDGET_BITS (BUDGET_BITS)
  ) u_eval (
    .item_i   (item_q),
    .ctl_i    (ctl_q),
    .polls_i  (polls_q),
    .budget_i (budget_q),
    .ctl_o    (ctl_d),
    .polls_o  (polls_d),
    .res_o    (res_d)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      ctl_q.waiting        <= 1'b0;
      ctl_q.wait_goal      <= ataw_pkg::GoalIdle;
      ctl_q.status_rec     <= 8'h00;
      ctl_q.error_rec      <= 8'h00;
      ctl_q.device_ready   <= 1'b1;
      polls_q              <= '0;
      budget_q             <= BUDGET_BITS'(ataw_pkg::ResetBudget);
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        ctl_q       <= ctl_d;
        polls_q     <= polls_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        budget_q <= BUDGET_BITS'(cfg_wdata_i);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.func        <= in_if.func;
      item_q.goal        <= in_if.goal;
      item_q.clear_error <= in_if.clear_error;
      item_q.status_byte <= in_if.status_byte;
      item_q.error_byte  <= in_if.error_byte;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Drive the result channel
  assign out_if.valid         = out_valid_q;
  assign out_if.done_res      = res_q.done_res;
  assign out_if.code          = res_q.code;
  assign out_if.saved_status  = res_q.saved_status;
  assign out_if.saved_error   = res_q.saved_error;
  assign out_if.device_absent = res_q.device_absent;

  // An armed wait always has polls left
  a_waiting_has_polls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.waiting |-> (polls_q != '0))
    else $error("waiting with an empty poll budget");

  // A finished wait never reports pending
  a_done_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.done_res) |-> (res_q.code != ataw_pkg::CodePending))
    else $error("done beat carries pending code");

  // A missing device stays missing
  a_absent_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_q.device_ready |=> !ctl_q.device_ready)
    else $error("device came back without reset");

  // A beat that leaves the input register lands in the result register
  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register lost a beat");

endmodule

### sv/ataw_eval.sv
// Next-state and result logic for one begin or status-sample beat.
module ataw_eval #(
  parameter int unsigned BUDGET_BITS = 24
) (
  input  ataw_pkg::item_t         item_i,
  input  ataw_pkg::ctl_t          ctl_i,
  input  logic [BUDGET_BITS-1:0]  polls_i,
  input  logic [BUDGET_BITS-1:0]  budget_i,
  output ataw_pkg::ctl_t          ctl_o,
  output logic [BUDGET_BITS-1:0]  polls_o,
  output ataw_pkg::res_t          res_o
);

  logic                   missing;
  logic                   bsy, drq, errb, df;
  logic                   hit;
  logic                   latch_err;
  logic [BUDGET_BITS-1:0] polls_dec;
  ataw_pkg::code_e        exhaust_code;
  ataw_pkg::code_e        code;
  logic                   done;

  // Decode the sampled status
  assign missing = (item_i.status_byte == ataw_pkg::StatusFloatLo) ||
                   (item_i.status_byte == ataw_pkg::StatusFloatHi);
  assign bsy  = item_i.status_byte[ataw_pkg::StBsyBit];
  assign drq  = item_i.status_byte[ataw_pkg::StDrqBit];
  assign errb = item_i.status_byte[ataw_pkg::StErrBit];
  assign df   = item_i.status_byte[ataw_pkg::StDfBit];
  assign latch_err = !missing && errb && !bsy;

  // Spend one poll, never below zero
  assign polls_dec = (polls_i != '0) ? polls_i - BUDGET_BITS'(1) : polls_i;

  // Goal met, or device error for goals other than idle, on a not-busy status
  always_comb begin
    hit = 1'b0;
    if (!bsy) begin
      if (ctl_i.wait_goal == ataw_pkg::GoalIdle) begin
        hit = !drq;
      end else if (errb || df) begin
        hit = 1'b1;
      end else if (ctl_i.wait_goal == ataw_pkg::GoalData) begin
        hit = drq;
      end else begin
        hit = !drq;
      end
    end
  end

  // Code when the budget runs dry
  always_comb begin
    exhaust_code = ataw_pkg::CodeTimeout;
    if (ctl_i.wait_goal == ataw_pkg::GoalData && !bsy && !drq) begin
      exhaust_code = ataw_pkg::CodeNoDrq;
    end else if (ctl_i.wait_goal != ataw_pkg::GoalData && !bsy && drq) begin
      exhaust_code = ataw_pkg::CodeProto;
    end
  end

  // Update the wait state
  always_comb begin
    ctl_o   = ctl_i;
    polls_o = polls_i;
    code    = ataw_pkg::CodeOk;
    done    = 1'b0;
    if (item_i.func == ataw_pkg::FuncBegin) begin
      ctl_o.wait_goal = (item_i.goal == ataw_pkg::GoalAlias) ? ataw_pkg::GoalComplete
                                                               : item_i.goal;
      if (item_i.clear_error) begin
        ctl_o.error_rec = 8'h00;
      end
      polls_o = budget_i;
      if (budget_i == '0) begin
        ctl_o.status_rec = ataw_pkg::StatusFloatHi;
        ctl_o.waiting    = 1'b0;
        done             = 1'b1;
        code             = ataw_pkg::CodeTimeout;
      end else begin
        ctl_o.waiting = 1'b1;
        code          = ataw_pkg::CodePending;
      end
    end else if (ctl_i.waiting) begin
      if (missing) begin
        ctl_o.status_rec   = item_i.status_byte;
        ctl_o.device_ready = 1'b0;
        code               = ataw_pkg::CodeNoDev;
      end else if (hit) begin
        ctl_o.status_rec = item_i.status_byte;
        if (latch_err) begin
          ctl_o.error_rec = item_i.error_byte;
        end
        code = (ctl_i.wait_goal != ataw_pkg::GoalIdle && (errb || df)) ?
               ataw_pkg::CodeDevErr : ataw_pkg::CodeOk;
      end else begin
        polls_o = polls_dec;
        if (polls_dec == '0) begin
          ctl_o.status_rec = item_i.status_byte;
          if (latch_err) begin
            ctl_o.error_rec = item_i.error_byte;
          end
          code = exhaust_code;
        end else begin
          code = ataw_pkg::CodePending;
        end
      end
      if (code != ataw_pkg::CodePending) begin
        ctl_o.waiting = 1'b0;
        done          = 1'b1;
      end
    end
  end

  // Build the result beat from the updated state
  always_comb begin
    res_o.done_res      = done;
    res_o.code          = code;
    res_o.saved_status  = ctl_o.status_rec;
    res_o.saved_error   = ctl_o.error_rec;
    res_o.device_absent = !ctl_o.device_ready;
  end

endmodule

### dv/ata_status_wait_engine_tb.sv
// Self-checking testbench for the ATA status wait engine: directed and random waits.
module ata_status_wait_engine_tb;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned HoldLength  = 400;

  // Typical status values, all but StBusy with DRDY set
  localparam logic [7:0] StIdle     = 8'h40;
  localparam logic [7:0] StBusy     = 8'h80;
  localparam logic [7:0] StBusyDrq  = 8'hc8;
  localparam logic [7:0] StDataReq  = 8'h48;
  localparam logic [7:0] StErr      = 8'h41;
  localparam logic [7:0] StFault    = 8'h60;
  localparam logic [7:0] StDrqErr   = 8'h49;

  localparam logic [23:0] ResetBudget24 = ataw_pkg::ResetBudget[23:0];

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [23:0] cfg_wdata_i;

  ataw_in_if  in_ch ();
  ataw_out_if out_ch ();

  ata_status_wait_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // Shadow of the wait engine state
  logic [23:0] budget_q  = ResetBudget24;
  logic        waiting_q = 1'b0;
  logic [1:0]  goal_q    = ataw_pkg::GoalIdle;
  logic [23:0] polls_q   = '0;
  logic [7:0]  status_q  = '0;
  logic [7:0]  err_q     = '0;
  logic        ready_q   = 1'b1;

  ataw_pkg::res_t expected_reports[$];
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_cycles   = 0;
  int unsigned stall_mode    = 0;

  // Toggle the clock
  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Record a status byte; latch the error byte on a settled ERR
  function automatic void note_status(logic [7:0] s, logic [7:0] e);
    status_q = s;
    if (s != ataw_pkg::StatusFloatLo && s != ataw_pkg::StatusFloatHi &&
        s[ataw_pkg::StErrBit] && !s[ataw_pkg::StBsyBit])
      err_q = e;
  endfunction

  // Advance the shadow state by one accepted beat and return its report
  function automatic ataw_pkg::res_t predict_wait(ataw_pkg::item_t it);
    ataw_pkg::res_t  r;
    ataw_pkg::code_e c;
    logic  bsy;
    logic  drq;
    logic  fault;
    logic  done;
    c    = ataw_pkg::CodeOk;
    done = 1'b0;
    bsy   = it.status_byte[ataw_pkg::StBsyBit];
    drq   = it.status_byte[ataw_pkg::StDrqBit];
    fault = it.status_byte[ataw_pkg::StErrBit] | it.status_byte[ataw_pkg::StDfBit];
    if (it.func == ataw_pkg::FuncBegin) begin
      goal_q = (it.goal == ataw_pkg::GoalAlias) ? ataw_pkg::GoalComplete : it.goal;
      if (it.clear_error)
        err_q = '0;
      polls_q = budget_q;
      if (polls_q == 0) begin
        note_status(ataw_pkg::StatusFloatHi, 8'h00);
        waiting_q = 1'b0;
        done      = 1'b1;
        c         = ataw_pkg::CodeTimeout;
      end else begin
        waiting_q = 1'b1;
        c         = ataw_pkg::CodePending;
      end
    end else if (waiting_q) begin
      if (it.status_byte == ataw_pkg::StatusFloatLo ||
          it.status_byte == ataw_pkg::StatusFloatHi) begin
        c       = ataw_pkg::CodeNoDev;
        ready_q = 1'b0;
      end else if (!bsy && goal_q == ataw_pkg::GoalIdle && !drq) begin
        c = ataw_pkg::CodeOk;
      end else if (!bsy && goal_q != ataw_pkg::GoalIdle && fault) begin
        c = ataw_pkg::CodeDevErr;
      end else if (!bsy && goal_q == ataw_pkg::GoalData && drq) begin
        c = ataw_pkg::CodeOk;
      end else if (!bsy && goal_q == ataw_pkg::GoalComplete && !drq) begin
        c = ataw_pkg::CodeOk;
      end else begin
        // Spend one poll; give up once the budget is gone
        if (polls_q != 0)
          polls_q--;
        if (polls_q != 0)
          c = ataw_pkg::CodePending;
        else if (goal_q == ataw_pkg::GoalData && !bsy && !drq)
          c = ataw_pkg::CodeNoDrq;
        else if (goal_q != ataw_pkg::GoalData && !bsy && drq)
          c = ataw_pkg::CodeProto;
        else
          c = ataw_pkg::CodeTimeout;
      end
      if (c != ataw_pkg::CodePending) begin
        note_status(it.status_byte, it.error_byte);
        waiting_q = 1'b0;
        done      = 1'b1;
      end
    end
    r.done_res      = done;
    r.code          = c;
    r.saved_status  = status_q;
    r.saved_error   = err_q;
    r.device_absent = !ready_q;
    return r;
  endfunction

  function automatic ataw_pkg::item_t rand_item(logic f);
    ataw_pkg::item_t it;
    it.func        = f;
    it.goal        = 2'($urandom_range(0, 3));
    it.clear_error = 1'($urandom_range(0, 1));
    it.status_byte = 8'($urandom_range(0, 255));
    it.error_byte  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic ataw_pkg::item_t make_item(logic f, logic [1:0] g, logic clr,
                                                logic [7:0] s, logic [7:0] e);
    ataw_pkg::item_t it;
    it.func        = f;
    it.goal        = g;
    it.clear_error = clr;
    it.status_byte = s;
    it.error_byte  = e;
    return it;
  endfunction

  // Offer one beat in bursts, with random gaps when gaps_on is set; predict it once accepted
  task automatic offer_item(ataw_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(0, 6);
        repeat (gap) begin
          @(negedge clk_i);
          in_ch.valid = 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.func        = it.func;
    in_ch.goal        = it.goal;
    in_ch.clear_error = it.clear_error;
    in_ch.status_byte = it.status_byte;
    in_ch.error_byte  = it.error_byte;
    in_ch.valid       = 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    expected_reports.push_back(predict_wait(it));
  endtask

  // Drop valid and let every outstanding report arrive
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [23:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    budget_q    = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 24'($urandom_range(0, 255));
  endtask

  // Send mostly well-formed waits: begin, busy polls, one settling status
  task automatic run_waits(int unsigned n);
    ataw_pkg::item_t it;
    int unsigned     sent;
    int unsigned     polls;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_item(rand_item(1'($urandom_range(0, 1))));
        sent++;
      end else begin
        offer_item(rand_item(ataw_pkg::FuncBegin));
        sent++;
        polls = $urandom_range(0, 6);
        repeat (polls) begin
          it = rand_item(ataw_pkg::FuncSample);
          it.status_byte = StBusy | 8'($urandom_range(0, 127));
          offer_item(it);
          sent++;
        end
        if ($urandom_range(0, 7) != 0) begin
          it = rand_item(ataw_pkg::FuncSample);
          it.status_byte[ataw_pkg::StBsyBit] = 1'b0;
          if ($urandom_range(0, 1) == 0) begin
            it.status_byte[ataw_pkg::StErrBit] = 1'b0;
            it.status_byte[ataw_pkg::StDfBit]  = 1'b0;
          end
          if ($urandom_range(0, 31) == 0)
            it.status_byte = $urandom_range(0, 1) ? ataw_pkg::StatusFloatHi
                                                  : ataw_pkg::StatusFloatLo;
          offer_item(it);
          sent++;
        end
      end
    end
  endtask

  // Each goal reaching its outcome, restarts and samples with no wait
  task automatic test_goal_outcomes();
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalAlias, 1'b1, 8'hff, 8'hff));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalIdle, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StBusy, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StBusyDrq, 8'h11));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StDataReq, 8'h22));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StIdle, 8'h33));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalData, 1'b1, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalData, 1'b0, StIdle, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalData, 1'b0, StDataReq, 8'h00));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalComplete, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalComplete, 1'b0, StErr, 8'ha5));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalAlias, 1'b0, 8'hff, 8'hff));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StDataReq, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StFault, 8'h5a));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalData, 1'b1, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalIdle, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StIdle, 8'h00));
  endtask

  // Budget of one poll gives each give-up code; zero budget ends at once
  task automatic test_budget_exhaust();
    write_budget(24'd1);
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalData, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StIdle, 8'h00));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalIdle, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StDrqErr, 8'hff));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalComplete, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StBusy, 8'h01));
    write_budget(24'd0);
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalComplete, 1'b1, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0, StIdle, 8'h77));
  endtask

  // Floating status bytes mark the device absent
  task automatic test_missing_device();
    write_budget(ResetBudget24);
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalIdle, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0,
                         ataw_pkg::StatusFloatLo, 8'h00));
    offer_item(make_item(ataw_pkg::FuncBegin, ataw_pkg::GoalData, 1'b0, 8'h00, 8'h00));
    offer_item(make_item(ataw_pkg::FuncSample, ataw_pkg::GoalIdle, 1'b0,
                         ataw_pkg::StatusFloatHi, 8'hff));
  endtask

  // Random waits over a range of budgets, extremes included
  task automatic test_random_waits();
    write_budget(24'd2);
    run_waits(200);
    write_budget(24'd1);
    run_waits(150);
    write_budget(24'($urandom_range(3, 6)));
    run_waits(360);
    write_budget(24'd0);
    run_waits(60);
    write_budget(24'hffffff);
    run_waits(150);
    gaps_on = 1'b0;
    write_budget(24'($urandom_range(7, 16)));
    run_waits(150);
    gaps_on = 1'b1;
    write_budget(24'($urandom_range(17, 24'hfffffe)));
    run_waits(200);
    write_budget(ResetBudget24);
    run_waits(150);
  endtask

  // Hold the output off for a long stretch while beats keep coming
  task automatic test_stalled_output();
    write_budget(24'd3);
    gaps_on = 1'b0;
    hold_requests++;
    run_waits(80);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = ataw_pkg::FuncBegin;
    in_ch.goal        = ataw_pkg::GoalIdle;
    in_ch.clear_error = 1'b0;
    in_ch.status_byte = '0;
    in_ch.error_byte  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_goal_outcomes();
    test_budget_exhaust();
    test_missing_device();
    test_random_waits();
    test_stalled_output();
    wait_drained();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Drive output ready: long hold first, else a stall pattern that changes over time
  always @(negedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen   = hold_requests;
      hold_cycles = HoldLength;
    end
    if (cycle_count % 50 == 0)
      stall_mode = $urandom_range(0, 3);
    if (hold_cycles != 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      case (stall_mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 9) >= 3);
        2: out_ch.ready = ((cycle_count % 9) < 6);
        default: out_ch.ready = ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  // Compare each result beat with the oldest expected report
  always @(posedge clk_i) begin : check_reports
    ataw_pkg::res_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no report expected");
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_ch.done_res);
          fail_count++;
        end
        if (out_ch.code !== want.code) begin
          $error("code: expected %0d, got %0d", want.code, out_ch.code);
          fail_count++;
        end
        if (out_ch.saved_status !== want.saved_status) begin
          $error("saved_status: expected %02h, got %02h", want.saved_status,
                 out_ch.saved_status);
          fail_count++;
        end
        if (out_ch.saved_error !== want.saved_error) begin
          $error("saved_error: expected %02h, got %02h", want.saved_error,
                 out_ch.saved_error);
          fail_count++;
        end
        if (out_ch.device_absent !== want.device_absent) begin
          $error("device_absent: expected %0d, got %0d", want.device_absent,
                 out_ch.device_absent);
          fail_count++;
        end
      end
    end
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
